@@ hdl/icfm_pkg.sv @@
// shared types and constants for the input capture frequency meter
`timescale 1ns / 1ps
package icfm_pkg;

   // fixed field widths
   localparam int RATE_BITS     = 24;
   localparam int INTERVAL_BITS = 8;
   localparam int STEP_BITS     = $clog2(RATE_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(RATE_BITS - 1);

   // register indexes on the csr port
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_RATE       = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPORT_INTERVAL = 1'b1;

   // register reset values
   localparam logic [RATE_BITS-1:0]     TICK_RATE_RESET       = 24'd2000000;
   localparam logic [INTERVAL_BITS-1:0] REPORT_INTERVAL_RESET = 8'd128;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DIV   = 3'b010,
      ST_STORE = 3'b100
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic step;
      logic store;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
      logic last_step;
      logic out_busy;
   } sts_type;

endpackage

@@ hdl/icfm_ctrl.sv @@
// controller state machine for the input capture frequency meter
`timescale 1ns / 1ps
module icfm_ctrl
   import icfm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // handshake and commands
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.accept = req_valid && req_ready;
      cmd.step   = (state_ff == ST_DIV);
      cmd.store  = (state_ff == ST_STORE) && !sts.out_busy;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && sts.hit) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.last_step) state_in = ST_STORE;
         end
         ST_STORE: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/icfm_dp.sv @@
// datapath: capture state, config registers, restoring divider, output register
`timescale 1ns / 1ps
module icfm_dp
   import icfm_pkg::*;
#(
   parameter int TIMESTAMP_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [RATE_BITS-1:0]      csr_wdata,
   input  logic [TIMESTAMP_BITS-1:0] req_capture_time,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RATE_BITS-1:0]      rsp_frequency,
   input  cmd_type                   cmd,
   output sts_type                   sts
);

   localparam int TB = TIMESTAMP_BITS;

   logic [RATE_BITS-1:0]     tick_rate_ff;
   logic [INTERVAL_BITS-1:0] interval_ff;
   logic [TB-1:0]            prev_ff;
   logic [INTERVAL_BITS-1:0] count_ff;
   logic [INTERVAL_BITS-1:0] count_in;
   logic [TB-1:0]            delta;
   logic [TB:0]              div_ff;
   logic [TB-1:0]            rem_ff;
   logic [RATE_BITS-1:0]     quot_ff;
   logic [STEP_BITS-1:0]     step_ff;
   logic [TB:0]              shifted;
   logic                     fits;
   logic [TB:0]              diff;
   logic                     rsp_valid_ff;
   logic [RATE_BITS-1:0]     freq_ff;

   // capture count and interval
   assign count_in = count_ff + INTERVAL_BITS'(1);
   assign delta    = req_capture_time - prev_ff;

   // one restoring divide step
   assign shifted = {rem_ff, quot_ff[RATE_BITS-1]};
   assign fits    = (shifted >= div_ff);
   assign diff    = shifted - div_ff;

   // status to controller
   always_comb begin
      sts.hit       = (count_in == interval_ff);
      sts.last_step = (step_ff == LAST_STEP);
      sts.out_busy  = rsp_valid_ff && !rsp_ready;
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
         interval_ff  <= REPORT_INTERVAL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TICK_RATE:       tick_rate_ff <= csr_wdata;
            CSR_REPORT_INTERVAL: interval_ff  <= csr_wdata[INTERVAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // capture state, updated on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         prev_ff  <= req_capture_time;
         count_ff <= sts.hit ? '0 : count_in;
      end
   end

   // divider operands and iteration
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         div_ff  <= {1'b0, delta} + (TB+1)'(1);
         rem_ff  <= '0;
         quot_ff <= tick_rate_ff;
      end else if (cmd.step) begin
         rem_ff  <= fits ? diff[TB-1:0] : shifted[TB-1:0];
         quot_ff <= {quot_ff[RATE_BITS-2:0], fits};
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.accept) begin
         step_ff <= '0;
      end else if (cmd.step) begin
         step_ff <= step_ff + STEP_BITS'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.store) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) freq_ff <= quot_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_frequency = freq_ff;

endmodule

@@ hdl/input_capture_frequency_meter.sv @@
// top level of the input capture frequency meter
`timescale 1ns / 1ps
// Each transfer on the req channel is one timer capture. Captures that do not
// complete a report interval keep req_ready high. The capture that completes
// the interval starts a restoring divide of tick_rate by the wrapped timer
// difference plus one; the divider retires one quotient bit a cycle, so that
// capture occupies the block through accept, 24 divide steps and a store that
// waits while the rsp side holds a previous result. The result sits in an
// output register, so new captures are taken while it waits to be read.
// Config registers are written on the csr port at index 0 (tick_rate) and
// index 1 (report_interval) and should only change while the block is idle.
module input_capture_frequency_meter
   import icfm_pkg::*;
#(
   parameter int TIMESTAMP_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [RATE_BITS-1:0]      csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [TIMESTAMP_BITS-1:0] req_capture_time,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RATE_BITS-1:0]      rsp_frequency
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   icfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   icfm_dp #(
      .TIMESTAMP_BITS (TIMESTAMP_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_capture_time (req_capture_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frequency    (rsp_frequency),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
